/* src/olis_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// olis_pkg: shared types and constants for the ordered list block
// Word layouts, command and status codes, controller states and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package olis_pkg;

   localparam int DEPTH  = 16;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam int CMD_W  = 3;
   localparam int POS_W  = 5;
   localparam int VAL_W  = 32;
   localparam int STS_W  = 2;
   localparam int FIDX_W = 4;
   localparam int FCNT_W = 5;

   localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT     = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_FIND_FIRST = 3'd3,
      CMD_FIND_LAST  = 3'd4
   } cmd_code_type;

   typedef enum logic [STS_W-1:0] {
      RSP_OK      = 2'd0,
      RSP_BAD_POS = 2'd1,
      RSP_FULL    = 2'd2
   } status_code_type;

   typedef struct packed {
      logic [CMD_W-1:0]        command;
      logic [POS_W-1:0]        position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STS_W-1:0]  status;
      logic              found;
      logic [FIDX_W-1:0] found_index;
      logic [FCNT_W-1:0] item_count;
      logic              is_full;
      logic              is_empty;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SHIFT,
      S_SH_WR,
      S_PUT,
      S_SCAN,
      S_SC_CMP,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request word, set up pointers and flags
      logic rd_en;      // read store at current address
      logic wr_shift;   // write read-back word one slot up
      logic wr_put;     // write new value at target slot
      logic ptr_step;   // advance pointer (down for insert/find last, up otherwise)
      logic cnt_inc;
      logic set_found;
      logic rsp_load;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_insert;
      logic is_search;
      logic refused;
      logic shift_done;
      logic scan_done;
      logic match;
      logic rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

/* src/ordered_list_insert_search.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// ordered_list_insert_search: fixed-depth ordered list with insert and search
//
//   port group   dir   handshake              word
//   req_         in    req_valid/req_ready    req_data  (command, position, value)
//   rsp_         out   rsp_valid/rsp_ready    rsp_data  (status, found, index, count, flags)
//
// One word at a time; a new word is taken in the idle cycle that follows the
// hand-off of the previous result to the output register. An insert moves the
// entries from the count down to its position up one slot each; a search
// compares entries in turn until a hit or the end of the list. Each move or
// compare follows a registered store read. Reset empties the list at once; no
// clearing pass. A held result stalls only the final step, and the next word
// is taken while a result waits.
// ---------------------------------------------------------------------------
module ordered_list_insert_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  olis_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output olis_pkg::rsp_type rsp_data
);
   import olis_pkg::*;

   ctrl_cmd_type  ctrl;
   dp_status_type stat;

   olis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   olis_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctrl      (ctrl),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // store is never written while a new word can be taken
   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      (ctrl.wr_shift || ctrl.wr_put) |-> !req_ready)
      else $error("store write while accepting");

   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == RSP_FULL) |-> rsp_data.is_full)
      else $error("full status without full flag");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |->
         (FCNT_W'(rsp_data.found_index) < rsp_data.item_count))
      else $error("found index beyond count");

   a_refused_not_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != RSP_OK) |-> !rsp_data.found)
      else $error("refused insert reports a hit");

endmodule

`default_nettype wire

/* src/olis_dp.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// olis_dp: ordered list datapath
// Element store (one write, one registered read per cycle), count, walk
// pointer, request holding registers and the result output register.
// ---------------------------------------------------------------------------
module olis_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  olis_pkg::req_type      req_data,
   input  olis_pkg::ctrl_cmd_type ctrl,
   output olis_pkg::dp_status_type stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output olis_pkg::rsp_type      rsp_data
);
   import olis_pkg::*;

   logic [VAL_W-1:0]  store_ff [DEPTH];
   logic [VAL_W-1:0]  rd_data_ff;

   logic [CMD_W-1:0]  cmd_ff,   cmd_in;
   logic [VAL_W-1:0]  val_ff,   val_in;
   logic [CNT_W-1:0]  tgt_ff,   tgt_in;
   logic [CNT_W-1:0]  ptr_ff,   ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              bad_ff,   bad_in;
   logic              full_ff,  full_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  idx_ff,   idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff,   rsp_in;

   logic              is_ins, is_srch, is_first, is_last;
   logic [CNT_W-1:0]  ptr_m1;
   logic [IDX_W-1:0]  scan_addr, rd_addr, wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic              wr_en;
   logic [STS_W-1:0]  sts_code;

   assign is_ins   = (cmd_ff == CMD_INSERT) || (cmd_ff == CMD_PUSH_FRONT)
                     || (cmd_ff == CMD_PUSH_BACK);
   assign is_first = (cmd_ff == CMD_FIND_FIRST);
   assign is_last  = (cmd_ff == CMD_FIND_LAST);
   assign is_srch  = is_first || is_last;

   assign ptr_m1    = ptr_ff - CNT_W'(1);
   assign scan_addr = is_first ? IDX_W'(ptr_ff) : IDX_W'(ptr_m1);
   assign rd_addr   = is_ins ? IDX_W'(ptr_m1) : scan_addr;

   assign wr_en   = ctrl.wr_shift || ctrl.wr_put;
   assign wr_addr = ctrl.wr_put ? IDX_W'(tgt_ff) : IDX_W'(ptr_ff);
   assign wr_data = ctrl.wr_put ? val_ff : rd_data_ff;

   always_comb begin
      stat.is_insert  = is_ins;
      stat.is_search  = is_srch;
      stat.refused    = bad_ff || full_ff;
      stat.shift_done = (ptr_ff == tgt_ff);
      stat.scan_done  = is_first ? (ptr_ff == count_ff) : (ptr_ff == '0);
      stat.match      = (rd_data_ff == val_ff);
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      priority if (!is_ins)  sts_code = RSP_OK;
      else if (bad_ff)       sts_code = RSP_BAD_POS;
      else if (full_ff)      sts_code = RSP_FULL;
      else                   sts_code = RSP_OK;
   end

   always_comb begin
      cmd_in       = cmd_ff;
      val_in       = val_ff;
      tgt_in       = tgt_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      bad_in       = bad_ff;
      full_in      = full_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (ctrl.load) begin
         cmd_in   = req_data.command;
         val_in   = req_data.value;
         bad_in   = (req_data.command == CMD_INSERT)
                    && (CMP_W'(req_data.position) > CMP_W'(count_ff));
         full_in  = (count_ff == CNT_W'(DEPTH));
         found_in = 1'b0;
         idx_in   = '0;
         unique case (req_data.command)
            CMD_INSERT:     tgt_in = CNT_W'(req_data.position);
            CMD_PUSH_BACK:  tgt_in = count_ff;
            default:        tgt_in = '0;
         endcase
         // insert walks down from the count; find first walks up from zero
         ptr_in = (req_data.command == CMD_FIND_FIRST) ? '0 : count_ff;
      end

      if (ctrl.ptr_step) begin
         ptr_in = (is_ins || is_last) ? ptr_m1 : ptr_ff + CNT_W'(1);
      end

      if (ctrl.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end

      if (ctrl.set_found) begin
         found_in = 1'b1;
         idx_in   = scan_addr;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.rsp_load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.status      = sts_code;
         rsp_in.found       = found_ff;
         rsp_in.found_index = FIDX_W'(idx_ff);
         rsp_in.item_count  = FCNT_W'(count_ff);
         rsp_in.is_full     = (count_ff == CNT_W'(DEPTH));
         rsp_in.is_empty    = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      val_ff   <= val_in;
      tgt_ff   <= tgt_in;
      ptr_ff   <= ptr_in;
      bad_ff   <= bad_in;
      full_ff  <= full_in;
      found_ff <= found_in;
      idx_ff   <= idx_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* src/olis_ctrl.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// olis_ctrl: ordered list sequencer
// Steps one command through shift or scan over the element store, an entry
// at a time, then hands the result to the output register.
// ---------------------------------------------------------------------------
module olis_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  olis_pkg::dp_status_type stat,
   output olis_pkg::ctrl_cmd_type  ctrl
);
   import olis_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECIDE;
         S_DECIDE: begin
            priority if (stat.is_insert) state_in = stat.refused ? S_RESP : S_SHIFT;
            else if (stat.is_search)     state_in = S_SCAN;
            else                         state_in = S_RESP;
         end
         S_SHIFT:  state_in = stat.shift_done ? S_PUT : S_SH_WR;
         S_SH_WR:  state_in = S_SHIFT;
         S_PUT:    state_in = S_RESP;
         S_SCAN:   state_in = stat.scan_done ? S_RESP : S_SC_CMP;
         S_SC_CMP: state_in = stat.match ? S_RESP : S_SCAN;
         S_RESP:   if (stat.rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         S_SHIFT:  ctrl.rd_en = !stat.shift_done;
         S_SH_WR: begin
            ctrl.wr_shift = 1'b1;
            ctrl.ptr_step = 1'b1;
         end
         S_PUT: begin
            ctrl.wr_put  = 1'b1;
            ctrl.cnt_inc = 1'b1;
         end
         S_SCAN:   ctrl.rd_en = !stat.scan_done;
         S_SC_CMP: begin
            ctrl.set_found = stat.match;
            ctrl.ptr_step  = !stat.match;
         end
         S_RESP:   ctrl.rsp_load = stat.rsp_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for the ordered list insert/search block
// Drives command words through the valid/ready request port and predicts
// each result from a local copy of the list. Every result word is checked
// field by field against the oldest pending prediction. Directed words cover
// the empty list, each insert kind, bad positions, duplicate searches and the
// full list; random traffic runs under several idle patterns plus one long
// output hold-off that backs the block up.
// ---------------------------------------------------------------------------
module tb_top;
   import olis_pkg::*;

   // command codes the block does not decode
   localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // local copy of the list
   logic [VAL_W-1:0] list_store [DEPTH];
   int               list_count = 0;

   rsp_type pending_rsp_q [$];
   int      mismatch_count = 0;
   int      send_gap_pct   = 8;
   int      rsp_stall_pct  = 84;
   int      rsp_hold_len   = 0;
   int      hold_left      = 0;

   ordered_list_insert_search u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Applies one command word to the local list and returns its result word.
   function automatic rsp_type apply_list_command(input req_type w);
      rsp_type r;
      int      slot;
      int      tgt;
      logic    is_ins;
      r      = '0;
      tgt    = 0;
      is_ins = 1'b1;
      case (w.command)
         CMD_INSERT:     tgt = int'(w.position);
         CMD_PUSH_FRONT: tgt = 0;
         CMD_PUSH_BACK:  tgt = list_count;
         default:        is_ins = 1'b0;
      endcase
      if (is_ins) begin
         // position check wins over the full check
         if (tgt > list_count) begin
            r.status = RSP_BAD_POS;
         end else if (list_count >= DEPTH) begin
            r.status = RSP_FULL;
         end else begin
            for (slot = list_count; slot > tgt; slot--)
               list_store[slot] = list_store[slot-1];
            list_store[tgt] = w.value;
            list_count++;
         end
      end else if (w.command == CMD_FIND_FIRST) begin
         for (slot = 0; slot < list_count; slot++) begin
            if (!r.found && list_store[slot] == w.value) begin
               r.found       = 1'b1;
               r.found_index = slot[FIDX_W-1:0];
            end
         end
      end else if (w.command == CMD_FIND_LAST) begin
         for (slot = list_count - 1; slot >= 0; slot--) begin
            if (!r.found && list_store[slot] == w.value) begin
               r.found       = 1'b1;
               r.found_index = slot[FIDX_W-1:0];
            end
         end
      end
      r.item_count = list_count[FCNT_W-1:0];
      r.is_full    = (list_count == DEPTH);
      r.is_empty   = (list_count == 0);
      return r;
   endfunction

   function automatic req_type word_of(input logic [CMD_W-1:0] cmd, input int pos,
                                       input logic [VAL_W-1:0] val);
      req_type w;
      w.command  = cmd;
      w.position = pos[POS_W-1:0];
      w.value    = val;
      return w;
   endfunction

   // Stored value (to hit duplicates and real matches), an extreme, or noise.
   function automatic logic [VAL_W-1:0] pick_value(input int reuse_pct);
      int roll;
      roll = $urandom_range(99, 0);
      if (list_count > 0 && roll < reuse_pct)
         return list_store[$urandom_range(list_count - 1, 0)];
      case ($urandom_range(7, 0))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         4:       return $urandom_range(15, 0);
         default: return $urandom();
      endcase
   endfunction

   function automatic req_type random_word();
      req_type w;
      int      pick;
      int      ins_pct;
      w       = '0;
      pick    = $urandom_range(99, 0);
      ins_pct = (list_count < DEPTH) ? 55 : 25;
      if (pick < ins_pct) begin
         w.command = CMD_W'($urandom_range(CMD_PUSH_BACK, CMD_INSERT));
         if ($urandom_range(3, 0) == 0)
            w.position = POS_W'($urandom());
         else
            w.position = POS_W'($urandom_range(list_count, 0));
         w.value = pick_value(30);
      end else if (pick < 95) begin
         w.command  = $urandom_range(1, 0) ? CMD_FIND_FIRST : CMD_FIND_LAST;
         w.position = POS_W'($urandom());
         w.value    = pick_value(70);
      end else begin
         w.command  = CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
         w.position = POS_W'($urandom());
         w.value    = $urandom();
      end
      return w;
   endfunction

   // Offers one word; valid stays up across back-to-back words.
   task automatic send_word(input req_type w);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      pending_rsp_q.push_back(apply_list_command(w));
   endtask

   always @(posedge clock) begin
      if (rsp_hold_len != 0) begin
         hold_left    = rsp_hold_len;
         rsp_hold_len = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   task automatic log_mismatch(input string what, input rsp_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t mismatch (%s): exp sts=%0d fnd=%0d idx=%0d cnt=%0d full=%0d empty=%0d",
                  $realtime, what, want.status, want.found, want.found_index,
                  want.item_count, want.is_full, want.is_empty,
                  "\n      got sts=%0d fnd=%0d idx=%0d cnt=%0d full=%0d empty=%0d",
                  rsp_data.status, rsp_data.found, rsp_data.found_index,
                  rsp_data.item_count, rsp_data.is_full, rsp_data.is_empty);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            log_mismatch("no word pending", '0);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_data.status !== want.status || rsp_data.found !== want.found ||
                rsp_data.found_index !== want.found_index ||
                rsp_data.item_count !== want.item_count ||
                rsp_data.is_full !== want.is_full || rsp_data.is_empty !== want.is_empty)
               log_mismatch("field", want);
         end
      end
   end

   task automatic test_empty_list();
      send_word(word_of(CMD_FIND_FIRST, 0, 32'd5));
      send_word(word_of(CMD_FIND_LAST, 31, 32'h0000_0000));
      send_word(word_of(CMD_INSERT, 1, 32'd9));
      send_word(word_of(CMD_SPARE_LAST, 31, 32'hFFFF_FFFF));
   endtask

   task automatic test_insert_kinds();
      send_word(word_of(CMD_INSERT, 0, 32'h7FFF_FFFF));
      send_word(word_of(CMD_PUSH_FRONT, 31, 32'h8000_0000));
      send_word(word_of(CMD_PUSH_BACK, 0, 32'h0000_0000));
      send_word(word_of(CMD_INSERT, 1, 32'hFFFF_FFFF));
      send_word(word_of(CMD_INSERT, 4, 32'hFFFF_FFFF));   // at the tail
      send_word(word_of(CMD_INSERT, 6, 32'h1234_5678));   // one past the tail
      send_word(word_of(CMD_SPARE_FIRST, 0, 32'hFFFF_FFFF));
      send_word(word_of(CMD_SPARE_MID, 2, 32'h8000_0000));
   endtask

   task automatic test_search_duplicates();
      send_word(word_of(CMD_FIND_FIRST, 0, 32'hFFFF_FFFF));
      send_word(word_of(CMD_FIND_LAST, 0, 32'hFFFF_FFFF));
      send_word(word_of(CMD_FIND_FIRST, 0, 32'h8000_0000));
      send_word(word_of(CMD_FIND_LAST, 0, 32'h0000_0000));
      send_word(word_of(CMD_FIND_FIRST, 0, 32'h0001_2345));
      send_word(word_of(CMD_FIND_LAST, 0, 32'h7FFF_FFFF));
   endtask

   task automatic test_random_traffic(input int n, input int gap_pct, input int stall_pct);
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      repeat (n) send_word(random_word());
   endtask

   task automatic test_full_list();
      while (list_count < DEPTH)
         send_word(word_of(CMD_PUSH_BACK, 0, $urandom()));
      send_word(word_of(CMD_PUSH_FRONT, 0, 32'd1));
      send_word(word_of(CMD_PUSH_BACK, 0, 32'd2));
      send_word(word_of(CMD_INSERT, DEPTH, 32'd3));       // in range, but full
      send_word(word_of(CMD_INSERT, DEPTH + 1, 32'd4));   // bad position beats full
      send_word(word_of(CMD_INSERT, 31, 32'd5));
      send_word(word_of(CMD_FIND_LAST, 0, list_store[DEPTH-1]));
   endtask

   // Long output hold while words keep coming, so the input side stalls.
   task automatic test_output_stall();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_len  = 300;
      repeat (40) send_word(random_word());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_insert_kinds();
      test_search_duplicates();
      test_random_traffic(280, 8, 84);
      test_full_list();
      test_random_traffic(280, 84, 8);
      test_random_traffic(280, 0, 0);
      test_output_stall();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (48) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
src/olis_pkg.sv
src/olis_dp.sv
src/olis_ctrl.sv
src/ordered_list_insert_search.sv
sim/tb_top.sv
